/* rtl/ihdr_pkg.sv */
package ihdr_pkg;

  // header geometry
  localparam int MAX_HDR_BYTES = 60;
  localparam int MIN_HDR_BYTES = 20;
  localparam int HL_W          = 6;     // width of ihl * 4
  localparam int SUM_W         = 20;

  localparam logic [7:0] IHL_MASK = 8'h0f;
  localparam int         IHL_UNIT = 4;

  // byte positions inside the ipv4 header
  localparam int POS_VER_IHL = 0;
  localparam int POS_FLAGS   = 6;
  localparam int POS_FRAG_LO = 7;
  localparam int POS_PROTO   = 9;
  localparam int POS_CSUM_HI = 10;
  localparam int POS_CSUM_LO = 11;

  localparam logic [3:0] IP_VERSION4 = 4'd4;
  localparam logic [7:0] PROTO_TCP   = 8'd6;
  localparam logic [7:0] DF_MASK     = 8'h40;
  localparam logic [6:0] FRAG_HI_MASK = 7'h7f;   // df, mf and offset bits of the flags byte

  typedef enum logic [1:0] {
    ST_COLLECT,
    ST_FIX,
    ST_DRAIN,
    ST_PASS
  } state_t;

  typedef struct packed {
    logic wr_en;    // write incoming byte at wr_pos
    logic fix_en;   // patch df and checksum cells
    logic shift;    // move every cell one step toward the head
  } chain_ctl_t;

endpackage

/* rtl/ihdr_cell.sv */
module ihdr_cell (
  input  logic       clk,
  input  logic       shift,
  input  logic [7:0] right,
  input  logic       load,
  input  logic [7:0] load_d,
  output logic [7:0] q
);

  always_ff @(posedge clk) begin
    if (shift) begin
      q <= right;
    end else if (load) begin
      q <= load_d;
    end
  end

endmodule

/* rtl/ihdr_chain.sv */
module ihdr_chain #(
  parameter int DEPTH = ihdr_pkg::MAX_HDR_BYTES,
  parameter int PW    = $clog2(DEPTH + 1)
) (
  input  logic                   clk,
  input  ihdr_pkg::chain_ctl_t   ctl,
  input  logic [PW-1:0]          wr_pos,
  input  logic [7:0]             wr_byte,
  input  logic [15:0]            ck,
  output logic [7:0]             head
);
  import ihdr_pkg::*;

  logic [7:0] q [DEPTH];

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic       ld;
    logic [7:0] d;
    logic [7:0] right;
    logic       fix_hit;

    if (i == DEPTH - 1) begin : g_tail
      assign right = 8'h00;
    end else begin : g_mid
      assign right = q[i+1];
    end

    if (i == POS_FLAGS) begin : g_df
      assign fix_hit = 1'b1;
      assign d       = ctl.fix_en ? (q[i] | DF_MASK) : wr_byte;
    end else if (i == POS_CSUM_HI) begin : g_ckh
      assign fix_hit = 1'b1;
      assign d       = ctl.fix_en ? ck[15:8] : wr_byte;
    end else if (i == POS_CSUM_LO) begin : g_ckl
      assign fix_hit = 1'b1;
      assign d       = ctl.fix_en ? ck[7:0] : wr_byte;
    end else begin : g_plain
      assign fix_hit = 1'b0;
      assign d       = wr_byte;
    end

    assign ld = (ctl.wr_en && (wr_pos == PW'(i))) || (ctl.fix_en && fix_hit);

    ihdr_cell u_cell (
      .clk    (clk),
      .shift  (ctl.shift),
      .right  (right),
      .load   (ld),
      .load_d (d),
      .q      (q[i])
    );
  end

  assign head = q[0];

endmodule

/* rtl/ipv4_tcp_dont_fragment_rewriter.sv */
// channel | direction | handshake           | payload
// s       | in        | s_tvalid / s_tready | s_tdata = data_byte, s_tlast = last
// m       | out       | m_tvalid / m_tready | m_tdata = out_byte, m_tlast = out_last,
//         |           |                     | m_tuser = header_rewritten
//
// header bytes are taken one per cycle into a row of byte cells, with no output
// a flush drains the held bytes through the cell row, one per cycle at the head
// cell while the output is free, after a checksum patch step when the header is
// rewritten; s_tready is low for the whole patch and drain
// after the flush, payload bytes pass one per cycle through the output register while it is free
// synchronous active-high reset clears control state; the cells need no clearing
module ipv4_tcp_dont_fragment_rewriter #(
  parameter int MAX_HEADER_BYTES = ihdr_pkg::MAX_HDR_BYTES
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,    // [7:0] data_byte
  input  logic       s_tlast,
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,    // [7:0] out_byte
  output logic       m_tlast,
  output logic [0:0] m_tuser     // [0] header_rewritten
);
  import ihdr_pkg::*;

  localparam int PW = $clog2(MAX_HEADER_BYTES + 1);
  localparam int CW = HL_W + 1;   // compare width for lengths

  state_t state, state_next;

  logic [PW-1:0]    held;        // bytes collected, then bytes left to drain
  logic [SUM_W-1:0] sum;         // one's-complement sum with df set, checksum zero
  logic             rw_flag;
  logic             lst_saved;
  logic [7:0]       ver_ihl;
  logic [7:0]       flags_hi;
  logic [7:0]       frag_lo;
  logic [7:0]       proto;

  logic             acc;
  logic             out_free;
  logic [PW-1:0]    held_next;
  logic [CW-1:0]    held_cmp;
  logic [HL_W-1:0]  hl;
  logic             ok;
  logic             decide;
  logic             flush_rw;
  logic             flush_plain;
  logic [7:0]       v;
  logic [SUM_W-1:0] sum_next;
  logic [16:0]      fold1;
  logic [15:0]      fold2;
  logic [15:0]      ck;
  logic [7:0]       head;
  logic             drain_last;
  chain_ctl_t       ctl;

  // ---------------------------------------------------------------- handshake
  assign out_free = !m_tvalid || m_tready;
  assign acc      = s_tvalid && s_tready;

  always_comb begin
    case (state)
      ST_COLLECT: s_tready = 1'b1;
      ST_PASS:    s_tready = out_free;
      default:    s_tready = 1'b0;   // fix and drain stall the input
    endcase
  end

  // ---------------------------------------------------------------- decision
  assign held_next = held + PW'(1);
  assign held_cmp  = CW'(held_next);
  assign hl        = HL_W'(ver_ihl & IHL_MASK) * HL_W'(IHL_UNIT);

  assign ok = (ver_ihl[7:4] == IP_VERSION4) && (proto == PROTO_TCP) &&
              ({1'b0, hl} >= CW'(MIN_HDR_BYTES)) &&
              ({1'b0, hl} <= CW'(MAX_HEADER_BYTES)) &&
              ((flags_hi[6:0] & FRAG_HI_MASK) == 7'd0) && (frag_lo == 8'd0);

  // header fields are all registered once twenty bytes are in
  assign decide      = acc && (state == ST_COLLECT) && (held_cmp >= CW'(MIN_HDR_BYTES));
  assign flush_rw    = decide && ok && (held_cmp == {1'b0, hl});
  assign flush_plain = (decide && !ok) ||
                       (acc && (state == ST_COLLECT) && !flush_rw &&
                        (s_tlast || (held_cmp >= CW'(MAX_HEADER_BYTES))));

  // ---------------------------------------------------------------- checksum
  always_comb begin
    if ((held == PW'(POS_CSUM_HI)) || (held == PW'(POS_CSUM_LO))) begin
      v = 8'h00;
    end else if (held == PW'(POS_FLAGS)) begin
      v = s_tdata | DF_MASK;
    end else begin
      v = s_tdata;
    end
  end

  // odd positions carry the low byte of a 16-bit word
  assign sum_next = sum + (held[0] ? SUM_W'(v) : SUM_W'({v, 8'h00}));

  assign fold1 = {1'b0, sum[15:0]} + 17'(sum[SUM_W-1:16]);
  assign fold2 = fold1[15:0] + 16'(fold1[16]);
  assign ck    = ~fold2;

  // ---------------------------------------------------------------- cell row
  assign drain_last = (held == PW'(1));

  always_comb begin
    ctl.wr_en  = acc && (state == ST_COLLECT);
    ctl.fix_en = (state == ST_FIX);
    ctl.shift  = (state == ST_DRAIN) && out_free;
  end

  ihdr_chain #(
    .DEPTH (MAX_HEADER_BYTES),
    .PW    (PW)
  ) u_chain (
    .clk     (clk),
    .ctl     (ctl),
    .wr_pos  (held),
    .wr_byte (s_tdata),
    .ck      (ck),
    .head    (head)
  );

  // ---------------------------------------------------------------- next state
  always_comb begin
    state_next = state;
    case (state)
      ST_COLLECT: begin
        if (flush_rw) begin
          state_next = ST_FIX;
        end else if (flush_plain) begin
          state_next = ST_DRAIN;
        end
      end
      ST_FIX: state_next = ST_DRAIN;
      ST_DRAIN: begin
        if (out_free && drain_last) begin
          state_next = lst_saved ? ST_COLLECT : ST_PASS;
        end
      end
      ST_PASS: begin
        if (acc && s_tlast) begin
          state_next = ST_COLLECT;
        end
      end
      default: state_next = ST_COLLECT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_COLLECT;
    end else begin
      state <= state_next;
    end
  end

  // ---------------------------------------------------------------- packet state
  always_ff @(posedge clk) begin
    if (rst) begin
      held      <= '0;
      sum       <= '0;
      rw_flag   <= 1'b0;
      lst_saved <= 1'b0;
    end else begin
      if (state == ST_COLLECT && acc) begin
        held      <= held_next;
        sum       <= sum_next;
        lst_saved <= s_tlast;
        rw_flag   <= flush_rw;
      end else if (ctl.shift) begin
        held <= held - PW'(1);
      end
      // a packet that ends leaves clean state for the next one
      if (state != ST_COLLECT && state_next == ST_COLLECT) begin
        sum     <= '0;
        rw_flag <= 1'b0;
      end
    end
  end

  // header fields needed for the decision
  always_ff @(posedge clk) begin
    if (state == ST_COLLECT && acc) begin
      if (held == PW'(POS_VER_IHL)) begin
        ver_ihl <= s_tdata;
      end
      if (held == PW'(POS_FLAGS)) begin
        flags_hi <= s_tdata;
      end
      if (held == PW'(POS_FRAG_LO)) begin
        frag_lo <= s_tdata;
      end
      if (held == PW'(POS_PROTO)) begin
        proto <= s_tdata;
      end
    end
  end

  // ---------------------------------------------------------------- output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (ctl.shift || (state == ST_PASS && acc)) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      m_tdata <= head;
      m_tlast <= lst_saved && drain_last;
      m_tuser <= rw_flag;
    end else if (state == ST_PASS && acc) begin
      m_tdata <= s_tdata;
      m_tlast <= s_tlast;
      m_tuser <= rw_flag;
    end
  end

`ifndef NO_ASSERTIONS
  // input must stall while the held header is patched or drained
  a_stall_burst: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FIX || state == ST_DRAIN) |-> !s_tready)
    else $error("input taken during header flush");

  // the checksum patch is a single cycle and always leads into the drain
  a_fix_to_drain: assert property (@(posedge clk) disable iff (rst)
    state == ST_FIX |=> state == ST_DRAIN)
    else $error("checksum patch not followed by drain");

  // the held count never runs past the cell row
  a_held_bound: assert property (@(posedge clk) disable iff (rst)
    held <= PW'(MAX_HEADER_BYTES))
    else $error("header count beyond cell row");

  // a drain never starts with nothing held
  a_drain_nonempty: assert property (@(posedge clk) disable iff (rst)
    state == ST_DRAIN |-> held != '0)
    else $error("drain with empty cell row");
`endif

endmodule

/* dv/df_rewrite_tracker.sv */
`timescale 1ns / 100ps

module df_rewrite_tracker (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  input  logic       s_tready,
  input  logic [7:0] s_tdata,
  input  logic       s_tlast,
  input  logic       m_tvalid,
  input  logic       m_tready,
  input  logic [7:0] m_tdata,
  input  logic       m_tlast,
  input  logic [0:0] m_tuser,
  output int         fail_count,
  output int         due_count,
  output int         pkts_seen,
  output int         rewrites_seen,
  output int         bytes_checked
);

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       rewritten;
  } fwd_byte_t;

  fwd_byte_t  fwd_due [$];

  // shadow of the header being collected
  logic [7:0]  hdr_cells [ihdr_pkg::MAX_HDR_BYTES];
  logic [5:0]  n_held;
  bit          past_header;
  logic [19:0] hdr_sum;
  bit          hdr_fixed;

  int n_fail;
  int n_pkts;
  int n_rewrites;
  int n_checked;

  function automatic bit hdr_qualifies();
    int hl;
    hl = (hdr_cells[ihdr_pkg::POS_VER_IHL] & ihdr_pkg::IHL_MASK) * ihdr_pkg::IHL_UNIT;
    return hdr_cells[ihdr_pkg::POS_VER_IHL][7:4] == ihdr_pkg::IP_VERSION4 &&
           hdr_cells[ihdr_pkg::POS_PROTO] == ihdr_pkg::PROTO_TCP &&
           hl >= ihdr_pkg::MIN_HDR_BYTES && hl <= ihdr_pkg::MAX_HDR_BYTES &&
           (hdr_cells[ihdr_pkg::POS_FLAGS][6:0] & ihdr_pkg::FRAG_HI_MASK) == 0 &&
           hdr_cells[ihdr_pkg::POS_FRAG_LO] == 8'd0;
  endfunction

  function automatic void clear_packet();
    n_held      = '0;
    past_header = 1'b0;
    hdr_sum     = '0;
    hdr_fixed   = 1'b0;
  endfunction

  // release the held header, patched with df and a fresh checksum when fix is set
  function automatic void flush_header(input bit fix, input logic lst);
    logic [19:0] s;
    logic [15:0] csum;
    fwd_byte_t   fb;
    if (fix) begin
      s = hdr_sum;
      s = {4'b0, s[15:0]} + {16'b0, s[19:16]};
      s = {4'b0, s[15:0]} + {16'b0, s[19:16]};
      csum = ~s[15:0];
      hdr_cells[ihdr_pkg::POS_FLAGS]   = hdr_cells[ihdr_pkg::POS_FLAGS] | ihdr_pkg::DF_MASK;
      hdr_cells[ihdr_pkg::POS_CSUM_HI] = csum[15:8];
      hdr_cells[ihdr_pkg::POS_CSUM_LO] = csum[7:0];
      n_rewrites++;
    end
    hdr_fixed = fix;
    for (int i = 0; i < n_held; i++) begin
      fb.data      = hdr_cells[i];
      fb.last      = (i + 1 == n_held) ? lst : 1'b0;
      fb.rewritten = fix;
      fwd_due.push_back(fb);
    end
    past_header = 1'b1;
  endfunction

  function automatic void model_byte_in(input logic [7:0] b, input logic lst);
    logic [7:0] v;
    logic [5:0] pos;
    int         hl;
    fwd_byte_t  fb;
    if (past_header) begin
      fb.data      = b;
      fb.last      = lst;
      fb.rewritten = hdr_fixed;
      fwd_due.push_back(fb);
    end else begin
      if (n_held < ihdr_pkg::MAX_HDR_BYTES) begin
        pos = n_held;
        hdr_cells[pos] = b;
        v = b;
        // checksum bytes count as zero, df counts as already set
        if (pos == ihdr_pkg::POS_CSUM_HI || pos == ihdr_pkg::POS_CSUM_LO) begin
          v = 8'd0;
        end else if (pos == ihdr_pkg::POS_FLAGS) begin
          v = v | ihdr_pkg::DF_MASK;
        end
        hdr_sum = hdr_sum + (pos[0] ? {12'b0, v} : {4'b0, v, 8'b0});
        n_held  = pos + 6'd1;
      end
      if (n_held >= ihdr_pkg::MIN_HDR_BYTES) begin
        hl = (hdr_cells[ihdr_pkg::POS_VER_IHL] & ihdr_pkg::IHL_MASK) * ihdr_pkg::IHL_UNIT;
        if (!hdr_qualifies()) begin
          flush_header(1'b0, lst);
        end else if (n_held == hl) begin
          flush_header(1'b1, lst);
        end
      end
      if (!past_header && (lst || n_held >= ihdr_pkg::MAX_HDR_BYTES)) begin
        flush_header(1'b0, lst);
      end
    end
    if (lst) begin
      clear_packet();
      n_pkts++;
    end
  endfunction

  function automatic void check_fwd(input logic [7:0] d, input logic l, input logic rw);
    fwd_byte_t want;
    if (fwd_due.size() == 0) begin
      $error("unexpected forwarded byte: out_byte %h out_last %b", d, l);
      n_fail++;
    end else begin
      want = fwd_due.pop_front();
      n_checked++;
      if (d !== want.data) begin
        $error("out_byte expected %h actual %h", want.data, d);
        n_fail++;
      end
      if (l !== want.last) begin
        $error("out_last expected %b actual %b", want.last, l);
        n_fail++;
      end
      if (rw !== want.rewritten) begin
        $error("header_rewritten expected %b actual %b", want.rewritten, rw);
        n_fail++;
      end
    end
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      fwd_due.delete();
      clear_packet();
      n_fail     = 0;
      n_pkts     = 0;
      n_rewrites = 0;
      n_checked  = 0;
    end else begin
      // predict first so a same-cycle pass-through finds its expectation
      if (s_tvalid && s_tready) model_byte_in(s_tdata, s_tlast);
      if (m_tvalid && m_tready) check_fwd(m_tdata, m_tlast, m_tuser[0]);
    end
    fail_count    <= n_fail;
    due_count     <= fwd_due.size();
    pkts_seen     <= n_pkts;
    rewrites_seen <= n_rewrites;
    bytes_checked <= n_checked;
  end

endmodule

/* dv/tb_ipv4_tcp_dont_fragment_rewriter.sv */
`timescale 1ns / 100ps

module tb_ipv4_tcp_dont_fragment_rewriter;

  // byte transfers offered per idling phase, whole packets rounded up
  localparam int PHASE_BYTES    = 16;
  // long receiver hold-off that backs the block up into its input
  localparam int HOLD_CYCLES    = 300;
  // cycles without any transfer before the run is declared hung
  localparam int STALL_LIMIT    = 5000;
  // tail after the last expected byte: longest flush burst plus margin
  localparam int DRAIN_CYCLES   = 80;

  // mf bit of the flags byte
  localparam logic [7:0] MF_BIT     = 8'h20;
  localparam logic [7:0] RESV_BIT   = 8'h80;
  localparam logic [7:0] OFF_HI_MAX = 8'h1f;

  typedef enum {FILL_RAND, FILL_ZERO, FILL_ONES} fill_t;
  typedef enum {
    PK_GOOD, PK_TRUNC, PK_BAD_VER, PK_BAD_PROTO, PK_SHORT_IHL,
    PK_DF_SET, PK_MF_SET, PK_FRAG_OFF, PK_NOISE
  } pkt_kind_t;

  logic       clk      = 1'b0;
  logic       rst      = 1'b1;
  logic       s_tvalid = 1'b0;
  logic       s_tready;
  logic [7:0] s_tdata  = 8'd0;
  logic       s_tlast  = 1'b0;
  logic       m_tvalid;
  logic       m_tready = 1'b0;
  logic [7:0] m_tdata;
  logic       m_tlast;
  logic [0:0] m_tuser;

  int fail_count;
  int due_count;
  int pkts_seen;
  int rewrites_seen;
  int bytes_checked;

  // idling knobs, written by the stimulus process only
  int sender_idle_pct = 0;
  int recv_stall_pct  = 0;
  bit pressure_go     = 1'b0;

  // owned by the receiver process
  bit pressure_done   = 1'b0;
  int hold_cnt        = 0;

  int quiet_cycles    = 0;
  int phase_bytes     = 0;

  logic [7:0] pkt_bytes [$];

  always #4 clk = ~clk;

  ipv4_tcp_dont_fragment_rewriter u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

  // watches both channels, predicts every forwarded byte and compares
  df_rewrite_tracker u_tracker (
    .clk           (clk),
    .rst           (rst),
    .s_tvalid      (s_tvalid),
    .s_tready      (s_tready),
    .s_tdata       (s_tdata),
    .s_tlast       (s_tlast),
    .m_tvalid      (m_tvalid),
    .m_tready      (m_tready),
    .m_tdata       (m_tdata),
    .m_tlast       (m_tlast),
    .m_tuser       (m_tuser),
    .fail_count    (fail_count),
    .due_count     (due_count),
    .pkts_seen     (pkts_seen),
    .rewrites_seen (rewrites_seen),
    .bytes_checked (bytes_checked)
  );

  // receiver: random stalls, or one long hold-off when asked
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (pressure_go && !pressure_done) begin
      m_tready <= 1'b0;
      hold_cnt <= hold_cnt + 1;
      if (hold_cnt == HOLD_CYCLES - 1) pressure_done <= 1'b1;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // watchdog on cycles with no transfer on either channel
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == STALL_LIMIT) begin
      $error("no transfer for %0d cycles", STALL_LIMIT);
      $display("Regression FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // one byte transfer, with random sender gaps in front of it
  task automatic send_byte(input logic [7:0] b, input logic lst);
    while ($urandom_range(99) < sender_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tlast  <= lst;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  task automatic send_packet();
    for (int i = 0; i < pkt_bytes.size(); i++) begin
      send_byte(pkt_bytes[i], i == pkt_bytes.size() - 1);
    end
  endtask

  // ipv4 header of ihl words (at least 20 bytes on the wire) plus payload
  task automatic build_header(input int ihl, input logic [3:0] ver,
                              input logic [7:0] proto, input logic [7:0] flags_hi,
                              input logic [7:0] frag_lo, input fill_t fill,
                              input int payload_len);
    int         hl;
    logic [7:0] fb;
    hl = (ihl * 4 < ihdr_pkg::MIN_HDR_BYTES) ? ihdr_pkg::MIN_HDR_BYTES : ihl * 4;
    pkt_bytes.delete();
    for (int i = 0; i < hl; i++) begin
      case (fill)
        FILL_ZERO: fb = 8'h00;
        FILL_ONES: fb = 8'hff;
        default:   fb = 8'($urandom_range(255));
      endcase
      if (i == ihdr_pkg::POS_VER_IHL)      fb = {ver, ihl[3:0]};
      else if (i == ihdr_pkg::POS_FLAGS)   fb = flags_hi;
      else if (i == ihdr_pkg::POS_FRAG_LO) fb = frag_lo;
      else if (i == ihdr_pkg::POS_PROTO)   fb = proto;
      pkt_bytes.push_back(fb);
    end
    repeat (payload_len) pkt_bytes.push_back(8'($urandom_range(255)));
  endtask

  task automatic trunc_to(input int n);
    while (pkt_bytes.size() > n) void'(pkt_bytes.pop_back());
  endtask

  task automatic good_packet(input int ihl, input fill_t fill, input int payload_len);
    build_header(ihl, ihdr_pkg::IP_VERSION4, ihdr_pkg::PROTO_TCP,
                 $urandom_range(1) ? RESV_BIT : 8'h00, 8'h00, fill, payload_len);
  endtask

  // mostly well-formed tcp packets with small headers, the rest malformed or noise
  task automatic random_packet();
    int         pick;
    int         ihl;
    int         plen;
    pkt_kind_t  kind;
    logic [7:0] resv;
    logic [3:0] ver;
    pick = $urandom_range(99);
    ihl  = ($urandom_range(7) == 0) ? $urandom_range(6, 15) : 5;
    plen = $urandom_range(0, 4);
    resv = $urandom_range(1) ? RESV_BIT : 8'h00;
    if (pick < 60)      kind = PK_GOOD;
    else if (pick < 70) kind = PK_TRUNC;
    else if (pick < 74) kind = PK_BAD_VER;
    else if (pick < 78) kind = PK_BAD_PROTO;
    else if (pick < 82) kind = PK_SHORT_IHL;
    else if (pick < 86) kind = PK_DF_SET;
    else if (pick < 90) kind = PK_MF_SET;
    else if (pick < 94) kind = PK_FRAG_OFF;
    else                kind = PK_NOISE;
    case (kind)
      PK_GOOD: good_packet(ihl, FILL_RAND, plen);
      PK_TRUNC: begin
        good_packet(ihl, FILL_RAND, plen);
        trunc_to($urandom_range(1, ihl * 4 - 1));
      end
      PK_BAD_VER: begin
        ver = 4'(($urandom_range(1, 15) + 4) % 16);   // anything but version 4
        build_header(ihl, ver, ihdr_pkg::PROTO_TCP, resv, 8'h00, FILL_RAND, plen);
      end
      PK_BAD_PROTO: build_header(ihl, ihdr_pkg::IP_VERSION4,
                                 8'(($urandom_range(1, 255) + 6) % 256), resv, 8'h00,
                                 FILL_RAND, plen);
      PK_SHORT_IHL: build_header($urandom_range(0, 4), ihdr_pkg::IP_VERSION4,
                                 ihdr_pkg::PROTO_TCP, resv, 8'h00, FILL_RAND, plen);
      PK_DF_SET: build_header(ihl, ihdr_pkg::IP_VERSION4, ihdr_pkg::PROTO_TCP,
                              resv | ihdr_pkg::DF_MASK | 8'($urandom_range(0, 63)),
                              8'h00, FILL_RAND, plen);
      PK_MF_SET: build_header(ihl, ihdr_pkg::IP_VERSION4, ihdr_pkg::PROTO_TCP,
                              resv | MF_BIT | 8'($urandom_range(0, 31)),
                              8'($urandom_range(255)), FILL_RAND, plen);
      PK_FRAG_OFF: build_header(ihl, ihdr_pkg::IP_VERSION4, ihdr_pkg::PROTO_TCP,
                                resv | 8'($urandom_range(0, 31)),
                                8'($urandom_range(1, 255)), FILL_RAND, plen);
      default: begin
        pkt_bytes.delete();
        repeat ($urandom_range(1, 30)) pkt_bytes.push_back(8'($urandom_range(255)));
      end
    endcase
    // malformed packets are sometimes cut short as well
    if (kind != PK_GOOD && kind != PK_TRUNC && $urandom_range(3) == 0) begin
      trunc_to($urandom_range(1, pkt_bytes.size()));
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // directed: one-byte segment, last mark before any decision
    pkt_bytes.delete();
    pkt_bytes.push_back({ihdr_pkg::IP_VERSION4, 4'd5});
    send_packet();
    // minimal qualifying header, all-ones filler for checksum carries
    good_packet(5, FILL_ONES, 1);
    send_packet();
    // offset in either byte, rejected on the decision byte that ends the segment
    build_header(5, ihdr_pkg::IP_VERSION4, ihdr_pkg::PROTO_TCP, OFF_HI_MAX, 8'hff,
                 FILL_RAND, 0);
    send_packet();

    // receiver holds off while the sender keeps offering
    pressure_go <= 1'b1;
    good_packet(5, FILL_RAND, 8);
    send_packet();

    // random packets: no idling, sender gaps, receiver stalls, both
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin sender_idle_pct = 0;  recv_stall_pct <= 0;  end
        1: begin sender_idle_pct = 48; recv_stall_pct <= 0;  end
        2: begin sender_idle_pct = 0;  recv_stall_pct <= 48; end
        default: begin sender_idle_pct = 36; recv_stall_pct <= 36; end
      endcase
      phase_bytes = 0;
      while (phase_bytes < PHASE_BYTES) begin
        random_packet();
        phase_bytes += pkt_bytes.size();
        send_packet();
      end
    end
    s_tvalid <= 1'b0;

    // let every predicted byte come out, then watch for stray output
    @(posedge clk);
    while (due_count != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d segments, %0d with df and checksum rewritten, %0d bytes checked",
             pkts_seen, rewrites_seen, bytes_checked);
    $display("idling: none, sender 48%%, receiver 48%%, both 36%%; one %0d-cycle hold-off",
             HOLD_CYCLES);
    if (fail_count == 0 && due_count == 0) begin
      $display("Regression PASS");
    end else begin
      if (due_count != 0) $error("%0d forwarded bytes never arrived", due_count);
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/ihdr_pkg.sv
rtl/ihdr_cell.sv
rtl/ihdr_chain.sv
rtl/ipv4_tcp_dont_fragment_rewriter.sv
dv/df_rewrite_tracker.sv
dv/tb_ipv4_tcp_dont_fragment_rewriter.sv
